// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- design/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Field widths, the process table entry and the result record.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int MAX_PROCS_DEF = 16;
   localparam int PRI_W         = 10;
   localparam int TIME_W        = 16;
   localparam int ID_W          = 5;
   localparam int OUT_W         = 21;

   typedef struct packed {
      logic [PRI_W-1:0]  prio;
      logic [TIME_W-1:0] arr;
      logic [TIME_W-1:0] rem;
      logic [TIME_W-1:0] bur;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0]  process_id;
      logic [OUT_W-1:0] completion_time;
      logic [OUT_W-1:0] turnaround;
      logic [OUT_W-1:0] waiting;
      logic             final_result;
   } result_type;

endpackage

// ----- design/pps_if.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler channels
// Valid/ready channels for process requests and completion results.
// ----------------------------------------------------------------------------
interface pps_req_if;
   import pps_pkg::*;

   logic              valid;
   logic              ready;
   logic [PRI_W-1:0]  priority_req;
   logic [TIME_W-1:0] arrival;
   logic [TIME_W-1:0] burst;
   logic              last_entry;

   modport source (output valid, output priority_req, output arrival, output burst,
                   output last_entry, input ready);
   modport sink (input valid, input priority_req, input arrival, input burst,
                 input last_entry, output ready);
endinterface

interface pps_rsp_if;
   import pps_pkg::*;

   logic             valid;
   logic             ready;
   logic [ID_W-1:0]  process_id;
   logic [OUT_W-1:0] completion_time;
   logic [OUT_W-1:0] turnaround;
   logic [OUT_W-1:0] waiting;
   logic             final_result;

   modport source (output valid, output process_id, output completion_time,
                   output turnaround, output waiting, output final_result, input ready);
   modport sink (input valid, input process_id, input completion_time,
                 input turnaround, input waiting, input final_result, output ready);
endinterface

// ----- design/pps_store.sv -----
// ----------------------------------------------------------------------------
// Process table
// One-port-write, registered-read table of process entries plus done flags.
// ----------------------------------------------------------------------------
module pps_store #(
   parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
   parameter int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  pps_pkg::entry_type  wr_entry,
   input  logic [IDX_W-1:0]    rd_addr,
   output pps_pkg::entry_type  rd_entry,
   output logic                rd_done,
   input  logic                done_set,
   input  logic [IDX_W-1:0]    done_addr,
   input  logic                done_clear
);
   import pps_pkg::*;

   entry_type              mem_ff [MAX_PROCS];
   entry_type              rd_entry_ff;
   logic [MAX_PROCS-1:0]   done_ff;
   logic                   rd_done_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_addr];
      rd_done_ff  <= done_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || done_clear) begin
         done_ff <= '0;
      end else if (done_set) begin
         done_ff[done_addr] <= 1'b1;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_done  = rd_done_ff;

endmodule

// ----- design/pps_core.sv -----
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Loads entries, scans the table through one compare unit and runs the
// chosen process until it completes or a new arrival may preempt it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pps_core #(
   parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
   parameter int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   pps_req_if.sink             req_bus,
   pps_rsp_if.source           rsp_bus,
   output logic                wr_en,
   output logic [IDX_W-1:0]    wr_addr,
   output pps_pkg::entry_type  wr_entry,
   output logic [IDX_W-1:0]    rd_addr,
   input  pps_pkg::entry_type  rd_entry,
   input  logic                rd_done,
   output logic                done_set,
   output logic [IDX_W-1:0]    done_addr,
   output logic                done_clear
);
   import pps_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int TICK_W = $clog2((2 ** TIME_W) * (MAX_PROCS + 1));

   typedef enum logic [5:0] {
      S_LOAD   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_UPDATE = 6'b001000,
      S_FINISH = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   finished_ff, finished_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               have_best_ff, have_best_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   entry_type          best_ff, best_in;
   logic               have_next_ff, have_next_in;
   logic [TIME_W-1:0]  next_arr_ff, next_arr_in;
   logic [TIME_W-1:0]  run_ff, run_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               issue;
   logic               start_scan;
   logic [TIME_W-1:0]  gap;
   logic [TIME_W-1:0]  run_base;
   logic [TIME_W-1:0]  new_rem;
   logic [TICK_W-1:0]  arr_ext;
   logic [IDX_W:0]     id_wide;
   entry_type          load_entry;

   assign issue    = (state_ff == S_SCAN) && (scan_ff < count_ff);
   assign rd_addr  = scan_ff[IDX_W-1:0];
   assign arr_ext  = TICK_W'(rd_entry.arr);
   assign gap      = next_arr_ff - tick_ff[TIME_W-1:0];
   assign run_base = (best_ff.rem == '0) ? TIME_W'(1) : best_ff.rem;
   assign new_rem  = (best_ff.rem == '0) ? '0 : best_ff.rem - run_ff;
   assign id_wide  = (IDX_W+1)'(best_idx_ff) + (IDX_W+1)'(1);

   always_comb begin
      load_entry.prio = req_bus.priority_req;
      load_entry.arr  = req_bus.arrival;
      load_entry.rem  = req_bus.burst;
      load_entry.bur  = req_bus.burst;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      finished_in  = finished_ff;
      tick_in      = tick_ff;
      scan_in      = scan_ff;
      rd_valid_in  = issue;
      rd_idx_in    = scan_ff[IDX_W-1:0];
      have_best_in = have_best_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      have_next_in = have_next_ff;
      next_arr_in  = next_arr_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_entry     = load_entry;
      done_set     = 1'b0;
      done_addr    = best_idx_ff;
      done_clear   = 1'b0;
      start_scan   = 1'b0;

      case (state_ff)
         S_LOAD: begin
            if (req_bus.valid) begin
               if (count_ff < CNT_W'(MAX_PROCS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_bus.last_entry) begin
                  start_scan = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (rd_valid_ff && !rd_done) begin
               if (arr_ext <= tick_ff) begin
                  if (!have_best_ff || (rd_entry.prio < best_ff.prio)) begin
                     have_best_in = 1'b1;
                     best_idx_in  = rd_idx_ff;
                     best_in      = rd_entry;
                  end
               end else if (!have_next_ff || (rd_entry.arr < next_arr_ff)) begin
                  have_next_in = 1'b1;
                  next_arr_in  = rd_entry.arr;
               end
            end
            if (!issue && !rd_valid_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!have_best_ff) begin
               tick_in    = TICK_W'(next_arr_ff);
               start_scan = 1'b1;
               state_in   = S_SCAN;
            end else begin
               run_in   = (have_next_ff && (gap < run_base)) ? gap : run_base;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            tick_in     = tick_ff + TICK_W'(run_ff);
            best_in.rem = new_rem;
            wr_en       = 1'b1;
            wr_addr     = best_idx_ff;
            wr_entry    = best_ff;
            wr_entry.rem = new_rem;
            if (new_rem == '0) begin
               done_set    = 1'b1;
               finished_in = finished_ff + CNT_W'(1);
               state_in    = S_FINISH;
            end else begin
               start_scan = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_FINISH: begin
            rsp_in.process_id      = ID_W'(id_wide);
            rsp_in.completion_time = OUT_W'(tick_ff);
            rsp_in.turnaround      = OUT_W'(tick_ff - TICK_W'(best_ff.arr));
            rsp_in.waiting         = OUT_W'(tick_ff - TICK_W'(best_ff.arr)
                                            - TICK_W'(best_ff.bur));
            rsp_in.final_result    = (finished_ff == count_ff);
            rsp_valid_in           = 1'b1;
            state_in               = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.final_result) begin
                  count_in    = '0;
                  finished_in = '0;
                  tick_in     = '0;
                  done_clear  = 1'b1;
                  state_in    = S_LOAD;
               end else begin
                  start_scan = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (start_scan) begin
         scan_in      = '0;
         have_best_in = 1'b0;
         have_next_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         finished_ff  <= '0;
         tick_ff      <= '0;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         have_best_ff <= 1'b0;
         have_next_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         tick_ff      <= tick_in;
         scan_ff      <= scan_in;
         rd_valid_ff  <= rd_valid_in;
         have_best_ff <= have_best_in;
         have_next_ff <= have_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      next_arr_ff <= next_arr_in;
      run_ff      <= run_in;
      rsp_ff      <= rsp_in;
   end

   assign req_bus.ready           = (state_ff == S_LOAD);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.process_id      = rsp_ff.process_id;
   assign rsp_bus.completion_time = rsp_ff.completion_time;
   assign rsp_bus.turnaround      = rsp_ff.turnaround;
   assign rsp_bus.waiting         = rsp_ff.waiting;
   assign rsp_bus.final_result    = rsp_ff.final_result;

   `ASSERT_ALWAYS(a_finished_bound, finished_ff <= count_ff, "finished count exceeds entries")
   `ASSERT_NEXT(a_tick_advances, state_ff == S_UPDATE, tick_ff > $past(tick_ff), "time did not advance")
   `ASSERT_IMPLIES(a_final_all_done, rsp_valid_ff && rsp_ff.final_result, finished_ff == count_ff, "final result with processes left")
   `ASSERT_NEXT(a_batch_cleared, rsp_valid_ff && rsp_bus.ready && rsp_ff.final_result, (count_ff == '0) && (state_ff == S_LOAD), "batch not cleared")

endmodule

// ----- design/preemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Request channel req_bus loads one process entry (priority, arrival, burst)
// per request; the request with last_entry set starts the simulation over the
// stored entries. Requests beyond MAX_PROCS are dropped, and a dropped request
// with last_entry still starts the run. req_bus is ready only while loading.
// Each scheduling round scans the n loaded entries through one shared compare
// unit, one entry per cycle, then decides and updates the chosen one; if none
// is ready, time jumps to the next arrival and the scan restarts. A round runs
// the chosen process until it completes or until the next arrival. Each
// completion passes the finish state before its result appears on rsp_bus,
// where it stays valid until the receiver takes it; the scheduler waits while
// the receiver stalls, and the next round starts in the cycle after the result
// is taken. After the final result is taken the batch is cleared and req_bus
// is ready again in the next cycle. Reset clears the batch.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pps_req_if.sink     req_bus,
   pps_rsp_if.source   rsp_bus
);
   import pps_pkg::*;

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_entry;
   logic               rd_done;
   logic               done_set;
   logic [IDX_W-1:0]   done_addr;
   logic               done_clear;

   pps_store #(
      .MAX_PROCS (MAX_PROCS),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_entry   (wr_entry),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry),
      .rd_done    (rd_done),
      .done_set   (done_set),
      .done_addr  (done_addr),
      .done_clear (done_clear)
   );

   pps_core #(
      .MAX_PROCS (MAX_PROCS),
      .IDX_W     (IDX_W)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_entry   (wr_entry),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry),
      .rd_done    (rd_done),
      .done_set   (done_set),
      .done_addr  (done_addr),
      .done_clear (done_clear)
   );

endmodule
